// ===== rtl/core/cdcr_pkg.sv =====
// Shared types and constants for the CD drive command interface.
// Used by every module under rtl/core.
`timescale 1ns / 1ps
package cdcr_pkg;

	localparam int PARAM_DEPTH = 16;
	localparam int RESPONSE_DEPTH = 16;
	localparam int PA_W = $clog2(PARAM_DEPTH);
	localparam int RA_W = $clog2(RESPONSE_DEPTH);
	localparam int PC_W = PA_W + 1;
	localparam int RC_W = RA_W + 1;

	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_EVENT = 2'd2;

	localparam logic [1:0] EV_DATA = 2'd1;

	localparam logic [7:0] CMD_GETSTAT = 8'h01;
	localparam logic [7:0] CMD_SETLOC = 8'h02;
	localparam logic [7:0] CMD_READN = 8'h06;
	localparam logic [7:0] CMD_PAUSE = 8'h09;
	localparam logic [7:0] CMD_SETMODE = 8'h0E;
	localparam logic [7:0] CMD_SEEKL = 8'h15;
	localparam logic [7:0] CMD_TEST = 8'h19;
	localparam logic [7:0] CMD_GETID = 8'h1A;
	localparam logic [7:0] TEST_VERSION = 8'h20;

	localparam logic [7:0] ST_SHELL = 8'h10;
	localparam logic [7:0] ST_READ = 8'h20;
	localparam logic [7:0] ST_SEEK = 8'h40;
	localparam logic [7:0] ST_PLAY = 8'h80;

	typedef struct packed {
		logic [1:0] operation;
		logic [1:0] offset;
		logic [7:0] write_value;
		logic [1:0] event_code;
	} in_word_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic irq_request;
		logic signed [19:0] sector_lba;
		logic sector_valid;
		logic fault;
	} out_word_t;

	// Back-end work kinds, decided by the front end
	typedef enum logic [3:0] {
		K_NOP, K_FAULT, K_STATUS, K_POP, K_IRQ_RD, K_INDEX, K_PUSH_PARAM,
		K_SET_EN, K_CLR_FLAG, K_EVENT, K_CMD
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] value;
		logic [1:0] code;
		logic sel;
	} job_t;

	typedef enum logic [1:0] {B_IDLE, B_RUN, B_OUT} bstate_t;

	function automatic logic [19:0] bcd_val(input logic [7:0] b);
		return 20'(b[7:4]) * 20'd10 + 20'(b[3:0]);
	endfunction

	function automatic logic [7:0] bcd_fix(input logic [7:0] b);
		return (b[3:0] == 4'd10) ? ((b + 8'd10) & 8'hF0) : b;
	endfunction

endpackage

// ===== rtl/core/cdcr_front.sv =====
// Front end: accepts port words and classifies them into jobs.
// Depends on cdcr_pkg.
`timescale 1ns / 1ps
module cdcr_front import cdcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_word_t in_data,
	output logic job_valid,
	input logic job_ready,
	output job_t job
);
	// index register is owned here since only writes to port 0 change it
	logic [1:0] idx_q;
	job_t j;
	logic acc;

	always_comb begin
		j = '{kind: K_NOP, value: in_data.write_value, code: in_data.event_code, sel: 1'b0};
		unique case (in_data.operation)
			OP_READ: begin
				if (in_data.offset == 2'd0) j.kind = K_STATUS;
				else if (in_data.offset == 2'd1) j.kind = K_POP;
				else if (in_data.offset == 2'd3 && idx_q[1] == 1'b0) begin
					j.kind = K_IRQ_RD;
					j.sel = idx_q[0];
				end else j.kind = K_FAULT;
			end
			OP_WRITE: begin
				if (in_data.offset == 2'd0) j.kind = K_INDEX;
				else if (in_data.offset == 2'd1 && idx_q == 2'd0) j.kind = K_CMD;
				else if (in_data.offset == 2'd2 && idx_q == 2'd0) j.kind = K_PUSH_PARAM;
				else if (in_data.offset == 2'd2 && idx_q == 2'd1) j.kind = K_SET_EN;
				else if (in_data.offset == 2'd3 && idx_q == 2'd0) j.kind = K_NOP;
				else if (in_data.offset == 2'd3 && idx_q == 2'd1) j.kind = K_CLR_FLAG;
				else j.kind = K_FAULT;
			end
			OP_EVENT: j.kind = K_EVENT;
			default: j.kind = K_NOP;
		endcase
	end

	assign in_ready = !job_valid || job_ready;
	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			job_valid <= 1'b0;
		end else begin
			if (acc) job_valid <= 1'b1;
			else if (job_ready) job_valid <= 1'b0;
			if (acc && j.kind == K_INDEX) idx_q <= in_data.write_value[1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) job <= j;
	end
endmodule

// ===== rtl/core/cdcr_queue.sv =====
// Short job queue between front and back ends.
// Depends on cdcr_pkg.
`timescale 1ns / 1ps
module cdcr_queue import cdcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input job_t wr_job,
	output logic rd_valid,
	input logic rd_ready,
	output job_t rd_job
);
	job_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 3'd4;
	assign rd_valid = cnt_q != 3'd0;
	assign rd_job = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end
endmodule

// ===== rtl/core/cdcr_back.sv =====
// Back end: runs jobs against FIFOs, status, interrupt and position state.
// Depends on cdcr_pkg.
`timescale 1ns / 1ps
module cdcr_back import cdcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic disc_present,
	input logic job_valid,
	output logic job_ready,
	input job_t job,
	output logic out_valid,
	input logic out_ready,
	output out_word_t out_data
);
	// FIFOs as circular buffers; data not reset
	logic [7:0] pmem_q [PARAM_DEPTH];
	logic [7:0] rmem_q [RESPONSE_DEPTH];
	logic [PA_W-1:0] prd_q;
	logic [RA_W-1:0] rrd_q;
	logic [PC_W-1:0] pcnt_q;
	logic [RC_W-1:0] rcnt_q;
	logic [7:0] stat_q, mm_q, ss_q, ff_q;
	logic [4:0] ien_q, iflg_q;

	bstate_t st_q, st_d;
	job_t cur_q;
	logic [3:0] step_q;
	logic [7:0] sub_q;
	out_word_t res_q, res_d;
	logic [19:0] lba_q;
	logic [1:0] lstep_q;

	// per-step actions
	logic push_r, pop_p, done, flt;
	logic [7:0] push_v;
	logic [7:0] pv;
	logic [7:0] rfront;

	assign pv = (pcnt_q == '0) ? 8'h00 : pmem_q[prd_q];
	assign rfront = rmem_q[rrd_q];

	always_comb begin
		push_r = 1'b0;
		push_v = stat_q;
		pop_p = 1'b0;
		done = 1'b1;
		flt = 1'b0;
		unique case (cur_q.kind)
			K_PUSH_PARAM, K_NOP, K_FAULT, K_STATUS, K_POP, K_IRQ_RD, K_INDEX,
			K_SET_EN, K_CLR_FLAG: flt = (cur_q.kind == K_FAULT);
			K_EVENT: done = (cur_q.code != EV_DATA) || (lstep_q == 2'd2);
			K_CMD: begin
				unique case (cur_q.value)
					CMD_GETSTAT: begin
						push_r = 1'b1;
						push_v = disc_present ? stat_q : ST_SHELL;
					end
					CMD_SETLOC: begin
						push_r = (step_q == 4'd0);
						pop_p = 1'b1;
						done = (step_q == 4'd2);
					end
					CMD_READN, CMD_PAUSE, CMD_SEEKL: begin
						push_r = 1'b1;
						done = (step_q == 4'd1);
					end
					CMD_SETMODE: begin
						push_r = 1'b1;
						pop_p = 1'b1;
					end
					CMD_TEST: begin
						pop_p = (step_q == 4'd0);
						push_r = (step_q != 4'd0) && (sub_q == TEST_VERSION);
						done = (step_q == 4'd4) || (step_q != 4'd0 && sub_q != TEST_VERSION);
						flt = (sub_q != TEST_VERSION);
						case (step_q)
							4'd1: push_v = 8'h94;
							4'd2: push_v = 8'h09;
							4'd3: push_v = 8'h19;
							default: push_v = 8'hC0;
						endcase
						if (step_q == 4'd0) done = 1'b0;
					end
					CMD_GETID: begin
						push_r = 1'b1;
						done = (step_q == 4'd8);
						case (step_q)
							4'd0: push_v = stat_q;
							4'd1: push_v = stat_q & 8'hF7;
							4'd3: push_v = 8'h20;
							4'd5: push_v = 8'h53;
							4'd6: push_v = 8'h43;
							4'd7: push_v = 8'h45;
							4'd8: push_v = 8'h41;
							default: push_v = 8'h00;
						endcase
					end
					default: flt = 1'b1;
				endcase
			end
			default: flt = 1'b1;
		endcase
	end

	// result word, captured on the last step of a job
	always_comb begin
		res_d = '0;
		res_d.fault = flt;
		case (cur_q.kind)
			K_STATUS: res_d.read_value = {2'b00, rcnt_q != '0,
				pcnt_q != PC_W'(PARAM_DEPTH), pcnt_q == '0, 3'b000};
			K_POP: res_d.read_value = (rcnt_q != '0) ? rfront : 8'h00;
			K_IRQ_RD: res_d.read_value = {3'b000, cur_q.sel ? iflg_q : ien_q};
			K_EVENT: begin
				res_d.irq_request = |(ien_q & (iflg_q | (lstep_q == 2'd0 ?
					5'(cur_q.code) : 5'd0)));
				if (cur_q.code == EV_DATA) begin
					res_d.sector_valid = 1'b1;
					res_d.sector_lba = lba_q + bcd_val(ff_q) - 20'd150;
				end
			end
			default: ;
		endcase
	end

	logic run;
	assign run = (st_q == B_RUN);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			B_IDLE: if (job_valid) st_d = B_RUN;
			B_RUN: if (done) st_d = B_OUT;
			B_OUT: if (out_ready) st_d = job_valid ? B_RUN : B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (st_q == B_IDLE) || (st_q == B_OUT && out_ready);
		out_valid = (st_q == B_OUT);
		out_data = res_q;
	end

	logic [7:0] smin, ssec, ssect;
	always_comb begin
		ssect = bcd_fix(ff_q + 8'd1);
		ssec = ss_q;
		if (ssect == 8'h75) begin
			ssec = ss_q + 8'd1;
			ssect = 8'h00;
		end
		ssec = bcd_fix(ssec);
		smin = mm_q;
		if (ssec == 8'h60) begin
			smin = mm_q + 8'd1;
			ssec = 8'h00;
		end
		smin = bcd_fix(smin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			step_q <= '0;
			lstep_q <= '0;
			prd_q <= '0;
			rrd_q <= '0;
			pcnt_q <= '0;
			rcnt_q <= '0;
			stat_q <= '0;
			ien_q <= '0;
			iflg_q <= '0;
			mm_q <= '0;
			ss_q <= '0;
			ff_q <= '0;
		end else begin
			st_q <= st_d;
			if (job_valid && job_ready) begin
				step_q <= '0;
				lstep_q <= '0;
			end
			if (run) begin
				step_q <= step_q + 4'd1;
				if (push_r && rcnt_q != RC_W'(RESPONSE_DEPTH)) rcnt_q <= rcnt_q + 1'b1;
				if (pop_p && pcnt_q != '0) begin
					prd_q <= prd_q + 1'b1;
					pcnt_q <= pcnt_q - 1'b1;
				end
				unique case (cur_q.kind)
					K_POP: if (rcnt_q != '0) begin
						rrd_q <= rrd_q + 1'b1;
						rcnt_q <= rcnt_q - 1'b1;
					end
					K_PUSH_PARAM: if (pcnt_q != PC_W'(PARAM_DEPTH)) pcnt_q <= pcnt_q + 1'b1;
					K_SET_EN: ien_q <= cur_q.value[4:0];
					K_CLR_FLAG: iflg_q <= iflg_q & ~cur_q.value[4:0];
					K_EVENT: begin
						if (lstep_q == 2'd0) iflg_q <= iflg_q | 5'(cur_q.code);
						lstep_q <= lstep_q + 2'd1;
						if (cur_q.code == EV_DATA && lstep_q == 2'd2) begin
							ff_q <= ssect;
							ss_q <= ssec;
							mm_q <= smin;
						end
					end
					K_CMD: begin
						if (cur_q.value == CMD_GETSTAT && disc_present)
							stat_q <= stat_q & ~ST_SHELL;
						if ((cur_q.value == CMD_READN) && step_q == 4'd0)
							stat_q <= stat_q | ST_READ;
						if ((cur_q.value == CMD_PAUSE) && step_q == 4'd0)
							stat_q <= stat_q & ~(ST_PLAY | ST_READ);
						if ((cur_q.value == CMD_SEEKL) && step_q == 4'd0)
							stat_q <= stat_q | ST_SEEK;
						if (cur_q.value == CMD_SETLOC) begin
							case (step_q)
								4'd0: mm_q <= pv;
								4'd1: ss_q <= pv;
								default: ff_q <= pv;
							endcase
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) cur_q <= job;
		if (run && cur_q.kind == K_CMD && cur_q.value == CMD_TEST && step_q == 4'd0)
			sub_q <= pv;
		if (run && push_r && rcnt_q != RC_W'(RESPONSE_DEPTH))
			rmem_q[RA_W'(32'(rrd_q) + 32'(rcnt_q))] <= push_v;
		if (run && cur_q.kind == K_PUSH_PARAM && pcnt_q != PC_W'(PARAM_DEPTH))
			pmem_q[PA_W'(32'(prd_q) + 32'(pcnt_q))] <= cur_q.value;
		// LBA over three steps: minutes, seconds, sectors
		if (run && cur_q.kind == K_EVENT) begin
			case (lstep_q)
				2'd0: lba_q <= bcd_val(mm_q) * 20'd4500;
				2'd1: lba_q <= lba_q + bcd_val(ss_q) * 20'd75;
				default: lba_q <= lba_q + bcd_val(ff_q) - 20'd150;
			endcase
		end
		if (run && done) res_q <= res_d;
	end
endmodule

// ===== rtl/core/cdrom_command_register_controller.sv =====
// Channel  | signals                    | direction
// in       | in_valid/in_ready/in_data  | words into front end
// out      | out_valid/out_ready/out_data | results from back end
// cfg      | cfg_we/cfg_wdata           | disc_present register
// Commands run longest in the back end; GetID pushes nine bytes, one per
// cycle on the response FIFO write port.
// Async reset clears control state; FIFO contents are not reset.
// A 4-entry job queue lets the front end keep accepting while the back stalls.
`timescale 1ns / 1ps
module cdrom_command_register_controller import cdcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_word_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_word_t out_data,
	input logic cfg_we,
	input logic cfg_wdata
);
	logic disc_q;
	logic f_valid, f_ready, q_valid, q_ready;
	job_t f_job, q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) disc_q <= 1'b1;
		else if (cfg_we) disc_q <= cfg_wdata;
	end

	cdcr_front u_front (.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job));
	cdcr_queue u_queue (.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_job(f_job), .rd_valid(q_valid), .rd_ready(q_ready), .rd_job(q_job));
	cdcr_back u_back (.clk, .arst_n, .disc_present(disc_q), .job_valid(q_valid),
		.job_ready(q_ready), .job(q_job), .out_valid, .out_ready, .out_data);
endmodule

// ===== rtl/core/cdcr_checker.sv =====
// Port-level checks on the top level, bound in below.
// Depends on cdcr_pkg.
`timescale 1ns / 1ps
module cdcr_checker import cdcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input out_word_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
	a_lba: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.sector_valid |-> out_data.sector_lba == '0) else $error("lba");
	a_evt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sector_valid |-> !out_data.fault && out_data.read_value == 8'h00)
		else $error("event word");
endmodule

bind cdrom_command_register_controller cdcr_checker u_chk (.clk, .arst_n, .out_valid,
	.out_ready, .out_data);

// ===== dv/cdrom_command_register_controller_tb.sv =====
// Testbench for the CD drive command interface: directed and random port traffic,
// checked word by word against an in-bench model. Depends on cdcr_pkg and the RTL top.
`timescale 1ns / 1ps
module cdrom_command_register_controller_tb;
	import cdcr_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam logic [1:0] EV_DONE = 2'd2;
	localparam logic [1:0] EV_ACK = 2'd3;
	localparam logic [1:0] PORT_STAT = 2'd0;
	localparam logic [1:0] PORT_DATA = 2'd1;
	localparam logic [1:0] PORT_PARAM = 2'd2;
	localparam logic [1:0] PORT_IRQ = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	in_word_t pending_words[$];
	out_word_t expected_words[$];
	out_word_t exp_w;
	int errors = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;
	logic in_taken = 1'b0;

	// model state
	logic disc_in;
	logic [1:0] m_index;
	logic [7:0] m_params[$];
	logic [7:0] m_resp[$];
	logic [7:0] m_status;
	logic [4:0] m_en;
	logic [4:0] m_flags;
	logic [7:0] m_min, m_sec, m_sct;

	always #5 clk = ~clk;

	cdrom_command_register_controller DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	function automatic logic [7:0] fifo_pop(ref logic [7:0] q[$]);
		if (q.size() == 0)
			return 8'h00;
		return q.pop_front();
	endfunction

	function automatic void resp_push(logic [7:0] v);
		if (m_resp.size() < RESPONSE_DEPTH)
			m_resp.push_back(v);
	endfunction

	function automatic int digits(logic [7:0] b);
		return int'(b[7:4]) * 10 + int'(b[3:0]);
	endfunction

	function automatic logic [7:0] carry_fix(logic [7:0] b);
		return (b[3:0] == 4'd10) ? ((b + 8'd10) & 8'hF0) : b;
	endfunction

	function automatic logic run_cmd(logic [7:0] c);
		logic [7:0] sub;
		case (c)
			CMD_GETSTAT: begin
				if (disc_in) begin
					resp_push(m_status);
					m_status &= ~ST_SHELL;
				end else
					resp_push(ST_SHELL);
			end
			CMD_SETLOC: begin
				resp_push(m_status);
				m_min = fifo_pop(m_params);
				m_sec = fifo_pop(m_params);
				m_sct = fifo_pop(m_params);
			end
			CMD_READN, CMD_PAUSE, CMD_SEEKL: begin
				resp_push(m_status);
				if (c == CMD_READN) m_status |= ST_READ;
				else if (c == CMD_PAUSE) m_status &= ~(ST_PLAY | ST_READ);
				else m_status |= ST_SEEK;
				resp_push(m_status);
			end
			CMD_SETMODE: begin
				resp_push(m_status);
				void'(fifo_pop(m_params));
			end
			CMD_TEST: begin
				sub = fifo_pop(m_params);
				if (sub != TEST_VERSION)
					return 1'b1;
				resp_push(8'h94); resp_push(8'h09); resp_push(8'h19); resp_push(8'hC0);
			end
			CMD_GETID: begin
				resp_push(m_status);
				resp_push(m_status & ~8'h08);
				resp_push(8'h00); resp_push(8'h20); resp_push(8'h00);
				resp_push(8'h53); resp_push(8'h43); resp_push(8'h45); resp_push(8'h41);
			end
			default: return 1'b1;
		endcase
		return 1'b0;
	endfunction

	function automatic out_word_t predict_word(in_word_t w);
		out_word_t r;
		int lba;
		r = '0;
		case (w.operation)
			OP_READ: begin
				if (w.offset == PORT_STAT)
					r.read_value = {2'b00, m_resp.size() != 0,
						m_params.size() != PARAM_DEPTH, m_params.size() == 0, 3'b000};
				else if (w.offset == PORT_DATA)
					r.read_value = fifo_pop(m_resp);
				else if (w.offset == PORT_IRQ && m_index == 2'd0)
					r.read_value = {3'b000, m_en};
				else if (w.offset == PORT_IRQ && m_index == 2'd1)
					r.read_value = {3'b000, m_flags};
				else
					r.fault = 1'b1;
			end
			OP_WRITE: begin
				if (w.offset == PORT_STAT)
					m_index = w.write_value[1:0];
				else if (w.offset == PORT_DATA && m_index == 2'd0)
					r.fault = run_cmd(w.write_value);
				else if (w.offset == PORT_PARAM && m_index == 2'd0) begin
					if (m_params.size() < PARAM_DEPTH)
						m_params.push_back(w.write_value);
				end else if (w.offset == PORT_PARAM && m_index == 2'd1)
					m_en = w.write_value[4:0];
				else if (w.offset == PORT_IRQ && m_index == 2'd0) begin
				end else if (w.offset == PORT_IRQ && m_index == 2'd1)
					m_flags &= ~w.write_value[4:0];
				else
					r.fault = 1'b1;
			end
			OP_EVENT: begin
				m_flags |= {3'b000, w.event_code};
				r.irq_request = |(m_en & m_flags);
				if (w.event_code == EV_DATA) begin
					lba = digits(m_min) * 4500 + digits(m_sec) * 75 + digits(m_sct) - 150;
					r.sector_lba = lba[19:0];
					r.sector_valid = 1'b1;
					m_sct = carry_fix(m_sct + 8'd1);
					if (m_sct == 8'h75) begin
						m_sec = m_sec + 8'd1;
						m_sct = 8'h00;
					end
					m_sec = carry_fix(m_sec);
					if (m_sec == 8'h60) begin
						m_min = m_min + 8'd1;
						m_sec = 8'h00;
					end
					m_min = carry_fix(m_min);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic in_word_t mk(logic [1:0] op, logic [1:0] off, logic [7:0] v,
			logic [1:0] ev);
		in_word_t w;
		w.operation = op;
		w.offset = off;
		w.write_value = v;
		w.event_code = ev;
		return w;
	endfunction

	function automatic logic [7:0] to_bcd(int n);
		return {4'(n / 10), 4'(n % 10)};
	endfunction

	function automatic logic [7:0] pick_cmd();
		case ($urandom_range(9))
			0: return CMD_GETSTAT;
			1: return CMD_SETLOC;
			2: return CMD_READN;
			3: return CMD_PAUSE;
			4: return CMD_SETMODE;
			5: return CMD_SEEKL;
			6: return CMD_TEST;
			7: return CMD_GETID;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic in_word_t rand_word();
		int r;
		logic [7:0] v;
		r = $urandom_range(99);
		v = 8'($urandom);
		if (r < 12) begin
			if ($urandom_range(9) < 8) v = 8'($urandom_range(1));
			return mk(OP_WRITE, PORT_STAT, v, 2'd0);
		end
		if (r < 32) return mk(OP_WRITE, PORT_DATA, pick_cmd(), 2'd0);
		if (r < 47) begin
			if ($urandom_range(3) == 0) v = TEST_VERSION;
			else if ($urandom_range(1) == 0) v = to_bcd($urandom_range(59));
			return mk(OP_WRITE, PORT_PARAM, v, 2'd0);
		end
		if (r < 52) return mk(OP_WRITE, PORT_IRQ, v, 2'd0);
		if (r < 70) return mk(OP_READ, PORT_DATA, v, 2'($urandom));
		if (r < 76) return mk(OP_READ, PORT_STAT, v, 2'd0);
		if (r < 81) return mk(OP_READ, 2'($urandom), v, 2'($urandom));
		if (r < 97) return mk(OP_EVENT, 2'($urandom), v,
			($urandom_range(19) == 0) ? 2'd0 : 2'($urandom_range(3, 1)));
		return mk(OP_IGNORED, 2'($urandom), v, 2'($urandom));
	endfunction

	task automatic put(in_word_t w);
		pending_words.push_back(w);
	endtask

	// wait until nothing is in flight, then write disc_present
	task automatic cfg_write(logic v);
		do @(negedge clk);
		while (pending_words.size() != 0 || expected_words.size() != 0 || in_valid);
		cfg_we = 1'b1;
		cfg_wdata = v;
		disc_in = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// driver: words go out at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
					in_data <= pending_words.pop_front();
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
			out_ready <= calm || ($urandom_range(99) >= 23);
		end
	end

	// monitor: prediction on acceptance, comparison on each result word
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_words.push_back(predict_word(in_data));
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: expected nothing, got %p", $time, out_data);
				end else begin
					exp_w = expected_words.pop_front();
					if (out_data !== exp_w) begin
						errors++;
						$display("%0t: expected %p, got %p", $time, exp_w, out_data);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
		in_taken <= arst_n && in_valid && in_ready;
	end

	initial begin
		disc_in = 1'b1;
		m_index = 2'd0;
		m_params.delete();
		m_resp.delete();
		m_status = 8'h00;
		m_en = 5'd0;
		m_flags = 5'd0;
		m_min = 8'h00;
		m_sec = 8'h00;
		m_sct = 8'h00;

		// interrupt registers
		put(mk(OP_WRITE, PORT_STAT, 8'h01, 2'd0));
		put(mk(OP_WRITE, PORT_PARAM, 8'hFF, 2'd0));
		put(mk(OP_EVENT, PORT_STAT, 8'h00, EV_ACK));
		put(mk(OP_READ, PORT_IRQ, 8'h00, 2'd0));
		put(mk(OP_WRITE, PORT_IRQ, 8'h03, 2'd0));
		put(mk(OP_EVENT, PORT_STAT, 8'h00, EV_DONE));
		put(mk(OP_READ, PORT_IRQ, 8'h00, 2'd0));
		put(mk(OP_READ, PORT_PARAM, 8'h00, 2'd0));
		put(mk(OP_WRITE, PORT_DATA, CMD_GETSTAT, 2'd0));
		put(mk(OP_WRITE, PORT_STAT, 8'h00, 2'd0));
		put(mk(OP_READ, PORT_IRQ, 8'h00, 2'd0));
		// position wrap across seconds and minutes
		put(mk(OP_WRITE, PORT_PARAM, 8'h00, 2'd0));
		put(mk(OP_WRITE, PORT_PARAM, 8'h59, 2'd0));
		put(mk(OP_WRITE, PORT_PARAM, 8'h73, 2'd0));
		put(mk(OP_WRITE, PORT_DATA, CMD_SETLOC, 2'd0));
		repeat (3) put(mk(OP_EVENT, PORT_STAT, 8'h00, EV_DATA));
		// response FIFO overflow and drain
		put(mk(OP_WRITE, PORT_DATA, CMD_GETID, 2'd0));
		put(mk(OP_WRITE, PORT_DATA, CMD_GETID, 2'd0));
		put(mk(OP_READ, PORT_STAT, 8'h00, 2'd0));
		repeat (18) put(mk(OP_READ, PORT_DATA, 8'h00, 2'd0));
		// parameter FIFO overflow, then Test
		put(mk(OP_WRITE, PORT_PARAM, TEST_VERSION, 2'd0));
		for (int i = 0; i < 16; i++)
			put(mk(OP_WRITE, PORT_PARAM, 8'(i), 2'd0));
		put(mk(OP_READ, PORT_STAT, 8'h00, 2'd0));
		put(mk(OP_WRITE, PORT_DATA, CMD_TEST, 2'd0));
		put(mk(OP_WRITE, PORT_DATA, CMD_TEST, 2'd0));
		repeat (5) put(mk(OP_READ, PORT_DATA, 8'h00, 2'd0));
		repeat (280) put(rand_word());

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		cfg_write(1'b0);
		calm = 1'b1;
		repeat (210) put(rand_word());
		cfg_write(1'b1);
		calm = 1'b0;
		repeat (150) put(rand_word());

		do @(negedge clk);
		while (pending_words.size() != 0 || expected_words.size() != 0 || in_valid);
		repeat (5) @(negedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
